// ===== rtl/pscp_pkg.sv =====
// package: shared widths, command codes, controller/datapath structs and saturation
package pscp_pkg;

  localparam int DEF_GRID_ROWS = 64;
  localparam int DEF_GRID_COLS = 64;

  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int VAL_W     = 16;
  localparam int COEF_W    = 32;
  localparam int RES_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAP_COEFF_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAP_COEFF_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_COEFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CUBIC_COEFF  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COUPLING     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_SCALE_X = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_SCALE_Y = 3'd7;

  // store read selects
  typedef logic [2:0] rd_sel_t;
  localparam rd_sel_t RD_NONE = 3'd0;
  localparam rd_sel_t RD_CTR  = 3'd1;
  localparam rd_sel_t RD_XP   = 3'd2;
  localparam rd_sel_t RD_XM   = 3'd3;
  localparam rd_sel_t RD_YP   = 3'd4;
  localparam rd_sel_t RD_YM   = 3'd5;

  // multiplier operand selects
  typedef logic [3:0] mul_sel_t;
  localparam mul_sel_t MUL_NONE = 4'd0;
  localparam mul_sel_t MUL_PP   = 4'd1;
  localparam mul_sel_t MUL_P2P  = 4'd2;
  localparam mul_sel_t MUL_CUBE = 4'd3;
  localparam mul_sel_t MUL_LIN  = 4'd4;
  localparam mul_sel_t MUL_CPA  = 4'd5;
  localparam mul_sel_t MUL_CPB  = 4'd6;
  localparam mul_sel_t MUL_LX   = 4'd7;
  localparam mul_sel_t MUL_LY   = 4'd8;
  localparam mul_sel_t MUL_GX   = 4'd9;
  localparam mul_sel_t MUL_GY   = 4'd10;
  localparam mul_sel_t MUL_FXL  = 4'd11;
  localparam mul_sel_t MUL_FXH  = 4'd12;
  localparam mul_sel_t MUL_FYL  = 4'd13;
  localparam mul_sel_t MUL_FYH  = 4'd14;

  // what to do with the registered product
  typedef logic [3:0] acc_op_t;
  localparam acc_op_t ACC_NONE  = 4'd0;
  localparam acc_op_t ACC_LOAD  = 4'd1;
  localparam acc_op_t ACC_ADD8  = 4'd2;
  localparam acc_op_t ACC_SUB8  = 4'd3;
  localparam acc_op_t ACC_MU_GX = 4'd4;
  localparam acc_op_t ACC_GY    = 4'd5;
  localparam acc_op_t ACC_FLO   = 4'd6;
  localparam acc_op_t ACC_FX    = 4'd7;
  localparam acc_op_t ACC_FY    = 4'd8;

  typedef struct packed {
    logic     load;
    logic     wr;
    rd_sel_t  rd;
    mul_sel_t mul;
    acc_op_t  acc;
  } dp_cmd_t;

  typedef struct packed {
    logic query;
    logic in_grid;
    logic mode;
  } dp_status_t;

  function automatic logic signed [RES_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [RES_W-1:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[RES_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/pscp_item_if.sv =====
// interface: input item channel
interface pscp_item_if import pscp_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [ROW_W-1:0]        row;
  logic [COL_W-1:0]        col;
  logic signed [VAL_W-1:0] field_value;
  logic signed [VAL_W-1:0] neighbour_a_value;
  logic signed [VAL_W-1:0] neighbour_b_value;

  modport source (
    output valid, cmd, row, col, field_value, neighbour_a_value, neighbour_b_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, row, col, field_value, neighbour_a_value, neighbour_b_value,
    output ready
  );
endinterface

// ===== rtl/pscp_result_if.sv =====
// interface: result item channel
interface pscp_result_if import pscp_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] chem_potential;
  logic signed [RES_W-1:0] force_x;
  logic signed [RES_W-1:0] force_y;

  modport source (
    output valid, chem_potential, force_x, force_y,
    input  ready
  );
  modport sink (
    input  valid, chem_potential, force_x, force_y,
    output ready
  );
endinterface

// ===== rtl/pscp_dp.sv =====
// datapath: config registers, cell stores, shared multiplier and accumulators
module pscp_dp import pscp_pkg::*; #(
  parameter int GRID_ROWS = DEF_GRID_ROWS,
  parameter int GRID_COLS = DEF_GRID_COLS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         item_cmd,
  input  logic [ROW_W-1:0]             item_row,
  input  logic [COL_W-1:0]             item_col,
  input  logic signed [VAL_W-1:0]      item_field,
  input  logic signed [VAL_W-1:0]      item_nb_a,
  input  logic signed [VAL_W-1:0]      item_nb_b,
  input  dp_cmd_t                      cmd,
  output dp_status_t                   status,
  output logic signed [RES_W-1:0]      chem_potential,
  output logic signed [RES_W-1:0]      force_x,
  output logic signed [RES_W-1:0]      force_y
);

  localparam int DEPTH = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);

  // configuration
  logic                     layer_mode;
  logic signed [COEF_W-1:0] lap_x, lap_y, lin_c, cub_c, cpl_c, gsx, gsy;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_mode <= 1'b0;
      lap_x      <= '0;
      lap_y      <= '0;
      lin_c      <= '0;
      cub_c      <= '0;
      cpl_c      <= '0;
      gsx        <= '0;
      gsy        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LAYER_MODE:   layer_mode <= cfg_data[0];
        REG_LAP_COEFF_X:  lap_x <= $signed(cfg_data);
        REG_LAP_COEFF_Y:  lap_y <= $signed(cfg_data);
        REG_LINEAR_COEFF: lin_c <= $signed(cfg_data);
        REG_CUBIC_COEFF:  cub_c <= $signed(cfg_data);
        REG_COUPLING:     cpl_c <= $signed(cfg_data);
        REG_GRAD_SCALE_X: gsx <= $signed(cfg_data);
        REG_GRAD_SCALE_Y: gsy <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // latched item
  logic                    item_query, item_in_grid;
  logic [RW-1:0]           r;
  logic [CW-1:0]           c;
  logic signed [VAL_W-1:0] wv_field, wv_a, wv_b;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_query   <= (item_cmd == CMD_QUERY);
      item_in_grid <= (32'(item_row) < 32'(GRID_ROWS)) && (32'(item_col) < 32'(GRID_COLS));
      r            <= RW'(item_row);
      c            <= CW'(item_col);
      wv_field     <= item_field;
      wv_a         <= item_nb_a;
      wv_b         <= item_nb_b;
    end
  end

  assign status.query   = item_query;
  assign status.in_grid = item_in_grid;
  assign status.mode    = layer_mode;

  // periodic wrap of the neighbour coordinates
  logic [RW-1:0] rp, rm, row_sel;
  logic [CW-1:0] cp, cm, col_sel;
  logic [AW-1:0] addr;

  assign rp = (r == RW'(GRID_ROWS - 1)) ? '0 : r + RW'(1);
  assign rm = (r == '0) ? RW'(GRID_ROWS - 1) : r - RW'(1);
  assign cp = (c == CW'(GRID_COLS - 1)) ? '0 : c + CW'(1);
  assign cm = (c == '0) ? CW'(GRID_COLS - 1) : c - CW'(1);

  always_comb begin
    row_sel = r;
    col_sel = c;
    case (cmd.rd)
      RD_XP:   row_sel = rp;
      RD_XM:   row_sel = rm;
      RD_YP:   col_sel = cp;
      RD_YM:   col_sel = cm;
      default: ;
    endcase
  end

  assign addr = AW'(32'(row_sel) * GRID_COLS + 32'(col_sel));

  // cell stores, one shared address port
  logic signed [VAL_W-1:0] field_mem [DEPTH];
  logic signed [VAL_W-1:0] nb_a_mem  [DEPTH];
  logic signed [VAL_W-1:0] nb_b_mem  [DEPTH];
  logic signed [VAL_W-1:0] p, pxp, pxm, pyp, pym, na, nb;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      field_mem[addr] <= wv_field;
      nb_a_mem[addr]  <= wv_a;
      nb_b_mem[addr]  <= wv_b;
    end
    case (cmd.rd)
      RD_CTR: begin
        p  <= field_mem[addr];
        na <= nb_a_mem[addr];
        nb <= nb_b_mem[addr];
      end
      RD_XP:   pxp <= field_mem[addr];
      RD_XM:   pxm <= field_mem[addr];
      RD_YP:   pyp <= field_mem[addr];
      RD_YM:   pym <= field_mem[addr];
      default: ;
    endcase
  end

  // stencil differences
  logic signed [17:0] lap_dx, lap_dy;
  logic signed [16:0] dif_a, dif_b, grad_dx, grad_dy;

  assign lap_dx  = 18'(pxp) + 18'(pxm) - (18'(p) <<< 1);
  assign lap_dy  = 18'(pyp) + 18'(pym) - (18'(p) <<< 1);
  assign dif_a   = 17'(p) - 17'(na);
  assign dif_b   = 17'(p) - 17'(nb);
  assign grad_dx = 17'(pxp) - 17'(pxm);
  assign grad_dy = 17'(pyp) - 17'(pym);

  // shared multiplier
  logic signed [32:0]       mul_a, mul_b;
  logic signed [65:0]       prod;
  logic signed [48:0]       gx, gy;
  logic signed [RES_W-1:0]  mu, fx;
  logic signed [63:0]       acc;
  logic signed [49:0]       facc;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul)
      MUL_PP:   begin mul_a = 33'(p);     mul_b = 33'(p);                      end
      MUL_P2P:  begin mul_a = 33'($signed(prod[31:0])); mul_b = 33'(p);        end
      MUL_CUBE: begin mul_a = 33'(cub_c); mul_b = 33'($signed(prod[47:16]));   end
      MUL_LIN:  begin mul_a = 33'(lin_c); mul_b = 33'(p);                      end
      MUL_CPA:  begin mul_a = 33'(cpl_c); mul_b = 33'(dif_a);                  end
      MUL_CPB:  begin mul_a = 33'(cpl_c); mul_b = 33'(dif_b);                  end
      MUL_LX:   begin mul_a = 33'(lap_x); mul_b = 33'(lap_dx);                 end
      MUL_LY:   begin mul_a = 33'(lap_y); mul_b = 33'(lap_dy);                 end
      MUL_GX:   begin mul_a = 33'(gsx);   mul_b = 33'(grad_dx);                end
      MUL_GY:   begin mul_a = 33'(gsy);   mul_b = 33'(grad_dy);                end
      MUL_FXL:  begin mul_a = 33'(mu);    mul_b = 33'({1'b0, gx[15:0]});       end
      MUL_FXH:  begin mul_a = 33'(mu);    mul_b = 33'(gx >>> 16);              end
      MUL_FYL:  begin mul_a = 33'(mu);    mul_b = 33'({1'b0, gy[15:0]});       end
      MUL_FYH:  begin mul_a = 33'(mu);    mul_b = 33'(gy >>> 16);              end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul != MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
  end

  // rounding of the Q.36 sum and of the force products
  logic signed [63:0] acc_rnd;
  logic signed [65:0] lo_rnd, hi_sum;
  logic signed [RES_W-1:0] f_sat;

  assign acc_rnd = acc + 64'sd524288;
  assign lo_rnd  = prod + 66'sd134217728;
  assign hi_sum  = prod + 66'(facc);
  assign f_sat   = sat32(hi_sum >>> 12);

  always_ff @(posedge clk) begin
    case (cmd.acc)
      ACC_LOAD: acc <= prod[63:0];
      ACC_ADD8: acc <= acc + (64'(prod) <<< 8);
      ACC_SUB8: acc <= acc - (64'(prod) <<< 8);
      ACC_MU_GX: begin
        mu <= sat32(66'(acc_rnd >>> 20));
        gx <= prod[48:0];
      end
      ACC_GY:  gy <= prod[48:0];
      ACC_FLO: facc <= 50'(lo_rnd >>> 16);
      ACC_FX:  fx <= f_sat;
      ACC_FY: begin
        chem_potential <= mu;
        force_x        <= fx;
        force_y        <= f_sat;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/pscp_ctrl.sv =====
// controller: item handshake, query sequencing and result valid
module pscp_ctrl import pscp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  output logic       result_valid,
  input  logic       result_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  localparam logic [3:0] LAST_STEP = 4'd13;

  logic [1:0] state, state_next;
  logic [3:0] step, step_next;
  logic       out_free, fy_issue;

  assign item_ready = (state == ST_IDLE);
  assign out_free   = !result_valid || result_ready;
  assign fy_issue   = (state == ST_DONE) && out_free;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '{load: 1'b0, wr: 1'b0, rd: RD_NONE, mul: MUL_NONE, acc: ACC_NONE};
    case (state)
      ST_IDLE: begin
        cmd.load = item_valid;
        if (item_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        step_next = '0;
        if (!status.in_grid) begin
          state_next = ST_IDLE;
        end else if (!status.query) begin
          cmd.wr     = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.rd     = RD_CTR;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        step_next = step + 4'd1;
        if (step == LAST_STEP) begin
          state_next = ST_DONE;
        end
        // reads, products and accumulation interleave on the one multiplier
        case (step)
          4'd0:  begin cmd.rd = RD_XP; cmd.mul = MUL_PP;                       end
          4'd1:  begin cmd.rd = RD_XM; cmd.mul = MUL_P2P;                      end
          4'd2:  begin cmd.rd = RD_YP; cmd.mul = MUL_CUBE;                     end
          4'd3:  begin cmd.rd = RD_YM; cmd.mul = MUL_LIN; cmd.acc = ACC_LOAD;  end
          4'd4:  begin cmd.mul = MUL_CPA; cmd.acc = ACC_SUB8;                  end
          4'd5:  begin cmd.mul = MUL_CPB; cmd.acc = ACC_ADD8;                  end
          4'd6:  begin
            cmd.mul = MUL_LX;
            cmd.acc = status.mode ? ACC_ADD8 : ACC_NONE;
          end
          4'd7:  begin cmd.mul = MUL_LY;  cmd.acc = ACC_SUB8;                  end
          4'd8:  begin cmd.mul = MUL_GX;  cmd.acc = ACC_SUB8;                  end
          4'd9:  begin cmd.mul = MUL_GY;  cmd.acc = ACC_MU_GX;                 end
          4'd10: begin cmd.mul = MUL_FXL; cmd.acc = ACC_GY;                    end
          4'd11: begin cmd.mul = MUL_FXH; cmd.acc = ACC_FLO;                   end
          4'd12: begin cmd.mul = MUL_FYL; cmd.acc = ACC_FX;                    end
          4'd13: begin cmd.mul = MUL_FYH; cmd.acc = ACC_FLO;                   end
          default: ;
        endcase
      end
      ST_DONE: begin
        // hold here while the previous result is still waiting
        if (out_free) begin
          cmd.acc    = ACC_FY;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (fy_issue) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/periodic_stencil_chemical_potential.sv =====
// top level: periodic stencil chemical potential and driving force unit
//
//   channel   dir  handshake      payload
//   item      in   valid/ready    cmd, row, col, field_value, neighbour_a_value,
//                                 neighbour_b_value
//   result    out  valid/ready    chem_potential, force_x, force_y
//   cfg       in   cfg_we         cfg_index, cfg_data (write only)
//
// a query holds the unit from acceptance through decode, the run steps and the
// done state, where its result is registered. one field store read port serves
// the five stencil reads and one shared 33x33 multiplier does the 14 products in
// turn. a write or an off-grid item goes back to idle after decode.
// rst clears the control state and the config registers; the cell stores come up
// undefined.
// an item is taken while the previous result waits; a query then stalls in its
// last cycle until the result register is free.
module periodic_stencil_chemical_potential import pscp_pkg::*; #(
  parameter int GRID_ROWS = DEF_GRID_ROWS,
  parameter int GRID_COLS = DEF_GRID_COLS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pscp_item_if.sink             item,
  pscp_result_if.source         result
);

  dp_cmd_t    cmd;
  dp_status_t status;

  pscp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  pscp_dp #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_cmd       (item.cmd),
    .item_row       (item.row),
    .item_col       (item.col),
    .item_field     (item.field_value),
    .item_nb_a      (item.neighbour_a_value),
    .item_nb_b      (item.neighbour_b_value),
    .cmd            (cmd),
    .status         (status),
    .chem_potential (result.chem_potential),
    .force_x        (result.force_x),
    .force_y        (result.force_y)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// testbench: cell writes and stencil queries checked against a predicted chemical potential and forces
module tb;
  import pscp_pkg::*;

  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    logic                    op;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] psi;
    logic signed [VAL_W-1:0] layer_a;
    logic signed [VAL_W-1:0] layer_b;
  } cell_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] mu;
    logic signed [RES_W-1:0] fx;
    logic signed [RES_W-1:0] fy;
  } potential_t;

  typedef enum int {
    COEF_MODERATE, COEF_FULL, COEF_EXTREME, COEF_MIXED, COEF_MAX, COEF_MIN
  } coef_style_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pscp_item_if   item_if ();
  pscp_result_if result_if ();

  periodic_stencil_chemical_potential DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_if),
    .result    (result_if)
  );

  // predicted block state
  logic signed [VAL_W-1:0] psi_mem     [0:4095];
  logic signed [VAL_W-1:0] layer_a_mem [0:4095];
  logic signed [VAL_W-1:0] layer_b_mem [0:4095];
  logic                    mid_layer;
  logic signed [31:0]      lap_x, lap_y, lin_a, cub_b, coup_k, gscale_x, gscale_y;

  // cells the stimulus has already written
  bit planned [0:63][0:63];

  cell_item_t cmd_backlog[$];
  potential_t pending_potentials[$];
  cell_item_t cur_item;
  potential_t res_tmp;
  potential_t want;

  int send_idle_pct;
  int recv_idle_pct;
  int err_count;
  logic hold_go;
  int hold_left;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [31:0] clamp32(input wide_t v);
    if (v > 96'sd2147483647) return 32'sh7fffffff;
    if (v < -96'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // updates the cell stores on a write, returns 1 with the result on a query
  function automatic bit compute_potential(input cell_item_t it, output potential_t res);
    logic [11:0] ctr, xp_i, xm_i, yp_i, ym_i;
    wide_t p, pxp, pxm, pyp, pym, pa, pb, acc, p3, mu, gx, gy;
    res = '0;
    ctr = {it.row, it.col};
    if (it.op == CMD_WRITE) begin
      psi_mem[ctr] = it.psi;
      layer_a_mem[ctr] = it.layer_a;
      layer_b_mem[ctr] = it.layer_b;
      return 1'b0;
    end
    // 64x64 grid: six-bit index arithmetic wraps at the edges
    xp_i = {it.row + 6'd1, it.col};
    xm_i = {it.row - 6'd1, it.col};
    yp_i = {it.row, it.col + 6'd1};
    ym_i = {it.row, it.col - 6'd1};
    p   = psi_mem[ctr];
    pxp = psi_mem[xp_i];
    pxm = psi_mem[xm_i];
    pyp = psi_mem[yp_i];
    pym = psi_mem[ym_i];
    pa  = layer_a_mem[ctr];
    pb  = layer_b_mem[ctr];
    // q.28 products lifted to q.36
    acc = -(lap_x * (pxp + pxm - 2 * p) + lap_y * (pyp + pym - 2 * p)) * 256;
    acc = acc - lin_a * p * 256;
    acc = acc + coup_k * (p - pa) * 256;
    if (mid_layer) acc = acc + coup_k * (p - pb) * 256;
    p3 = (p * p * p) >>> 16;
    acc = acc + cub_b * p3;
    mu = clamp32((acc + 96'sd524288) >>> 20);
    gx = (pxp - pxm) * gscale_x;
    gy = (pyp - pym) * gscale_y;
    res.mu = mu[31:0];
    res.fx = clamp32((mu * gx + 96'sd134217728) >>> 28);
    res.fy = clamp32((mu * gy + 96'sd134217728) >>> 28);
    return 1'b1;
  endfunction

  function automatic logic signed [15:0] rand_val();
    logic signed [15:0] v;
    case ($urandom_range(11))
      0: v = 16'sh7fff;
      1: v = 16'sh8000;
      2: v = 16'sh0000;
      3: v = 16'shffff;
      default: v = 16'($urandom_range(65535));
    endcase
    return v;
  endfunction

  // edges for wrap, a hot window for reuse, anywhere else
  function automatic int pick_coord();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) begin
      case ($urandom_range(3))
        0: return 0;
        1: return 1;
        2: return 62;
        default: return 63;
      endcase
    end
    if (roll < 70) return $urandom_range(35, 28);
    return $urandom_range(63);
  endfunction

  function automatic void push_write(input int r, input int c, input logic signed [15:0] f,
                                     input logic signed [15:0] a, input logic signed [15:0] b);
    cell_item_t it;
    it.op = CMD_WRITE;
    it.row = ROW_W'(r);
    it.col = COL_W'(c);
    it.psi = f;
    it.layer_a = a;
    it.layer_b = b;
    planned[r][c] = 1'b1;
    cmd_backlog.push_back(it);
  endfunction

  // value fields of a query carry junk on purpose
  function automatic void push_query(input int r, input int c);
    cell_item_t it;
    it.op = CMD_QUERY;
    it.row = ROW_W'(r);
    it.col = COL_W'(c);
    it.psi = rand_val();
    it.layer_a = rand_val();
    it.layer_b = rand_val();
    cmd_backlog.push_back(it);
  endfunction

  function automatic void add_random(input int n);
    int added, r, c, k, nr, nc;
    added = 0;
    while (added < n) begin
      r = pick_coord();
      c = pick_coord();
      if ($urandom_range(99) < 15) begin
        push_write(r, c, rand_val(), rand_val(), rand_val());
        added++;
      end else begin
        // fill in the stencil, sometimes rewriting, then query its center
        for (k = 0; k < 5; k++) begin
          nr = r;
          nc = c;
          case (k)
            1: nr = (r + 1) % 64;
            2: nr = (r + 63) % 64;
            3: nc = (c + 1) % 64;
            4: nc = (c + 63) % 64;
            default: ;
          endcase
          if (!planned[nr][nc] || $urandom_range(9) == 0) begin
            push_write(nr, nc, rand_val(), rand_val(), rand_val());
            added++;
          end
        end
        push_query(r, c);
        added++;
      end
    end
  endfunction

  function automatic logic [31:0] pick_coef(input coef_style_t style);
    logic [31:0] v;
    case (style)
      COEF_MODERATE: v = int'($urandom_range(131072)) - 65536;
      COEF_FULL:     v = $urandom;
      COEF_EXTREME: begin
        case ($urandom_range(4))
          0: v = 32'h7fffffff;
          1: v = 32'h80000000;
          2: v = 32'h00000000;
          3: v = 32'h00000001;
          default: v = 32'hffffffff;
        endcase
      end
      COEF_MAX: v = 32'h7fffffff;
      COEF_MIN: v = 32'h80000000;
      default:  v = pick_coef(coef_style_t'($urandom_range(2)));
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_LAYER_MODE:   mid_layer = data[0];
      REG_LAP_COEFF_X:  lap_x = data;
      REG_LAP_COEFF_Y:  lap_y = data;
      REG_LINEAR_COEFF: lin_a = data;
      REG_CUBIC_COEFF:  cub_b = data;
      REG_COUPLING:     coup_k = data;
      REG_GRAD_SCALE_X: gscale_x = data;
      REG_GRAD_SCALE_Y: gscale_y = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // writes and off-grid items leave no result, so allow their cycles after the last one
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || item_if.valid || pending_potentials.size() != 0)
      @(negedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic setup_phase(input coef_style_t style, input logic mode,
                             input int sidle, input int ridle);
    wait_idle();
    write_reg(REG_LAYER_MODE, {31'd0, mode});
    write_reg(REG_LAP_COEFF_X, pick_coef(style));
    write_reg(REG_LAP_COEFF_Y, pick_coef(style));
    write_reg(REG_LINEAR_COEFF, pick_coef(style));
    write_reg(REG_CUBIC_COEFF, pick_coef(style));
    write_reg(REG_COUPLING, pick_coef(style));
    write_reg(REG_GRAD_SCALE_X, pick_coef(style));
    write_reg(REG_GRAD_SCALE_Y, pick_coef(style));
    @(posedge clk);
    send_idle_pct <= sidle;
    recv_idle_pct <= ridle;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] got_v);
    if (exp_v !== got_v) begin
      err_count++;
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
    end
  endtask

  // driver: predicts each accepted item, then offers the next one
  always @(posedge clk) begin
    if (rst) begin
      item_if.valid <= 1'b0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        if (compute_potential(cur_item, res_tmp)) pending_potentials.push_back(res_tmp);
      end
      if (!item_if.valid || item_if.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = cmd_backlog.pop_front();
          item_if.valid <= 1'b1;
          item_if.cmd <= cur_item.op;
          item_if.row <= cur_item.row;
          item_if.col <= cur_item.col;
          item_if.field_value <= cur_item.psi;
          item_if.neighbour_a_value <= cur_item.layer_a;
          item_if.neighbour_b_value <= cur_item.layer_b;
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_potentials.size() == 0) begin
        err_count++;
        $display("%0t: result with nothing expected, mu %0d", $time,
                 result_if.chem_potential);
      end else begin
        want = pending_potentials.pop_front();
        check_field("chem_potential", want.mu, result_if.chem_potential);
        check_field("force_x", want.fx, result_if.force_x);
        check_field("force_y", want.fy, result_if.force_y);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_LAYER_MODE;
    cfg_data = '0;
    item_if.valid = 1'b0;
    item_if.cmd = CMD_WRITE;
    item_if.row = '0;
    item_if.col = '0;
    item_if.field_value = '0;
    item_if.neighbour_a_value = '0;
    item_if.neighbour_b_value = '0;
    result_if.ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    err_count = 0;
    hold_go = 1'b0;
    mid_layer = 1'b0;
    lap_x = 0; lap_y = 0; lin_a = 0; cub_b = 0; coup_k = 0; gscale_x = 0; gscale_y = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: corner stencils with wrap on both axes, field extremes
    setup_phase(COEF_MODERATE, 1'b1, 25, 57);
    push_write(0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff);
    push_write(1, 0, 16'sh8000, 16'sh0000, 16'shffff);
    push_write(63, 0, 16'sh7fff, 16'sh7fff, 16'sh8000);
    push_write(0, 1, 16'sh0000, 16'sh0001, 16'sh0000);
    push_write(0, 63, 16'shffff, 16'sh8000, 16'sh7fff);
    push_query(0, 0);
    push_write(63, 63, 16'sh8000, 16'sh8000, 16'sh8000);
    push_write(62, 63, 16'sh7fff, 16'sh0000, 16'sh0000);
    push_write(63, 62, 16'sh8000, 16'sh7fff, 16'sh7fff);
    push_query(63, 63);
    push_write(0, 0, 16'sh8000, 16'sh7fff, 16'sh8000);
    push_query(0, 0);
    push_write(0, 0, 16'sh0000, 16'sh0000, 16'sh0000);
    push_query(0, 0);
    push_query(63, 63);

    setup_phase(COEF_MODERATE, 1'b0, 25, 57);
    add_random(300);
    setup_phase(COEF_MIXED, 1'b1, 25, 57);
    add_random(300);
    setup_phase(COEF_MAX, 1'b1, 57, 25);
    add_random(300);
    setup_phase(COEF_MIN, 1'b0, 57, 25);
    add_random(300);
    setup_phase(COEF_MODERATE, 1'b1, 0, 0);
    add_random(300);
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    setup_phase(COEF_MIXED, 1'b0, 0, 0);
    add_random(300);

    wait_idle();
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pscp_pkg.sv
rtl/pscp_item_if.sv
rtl/pscp_result_if.sv
rtl/pscp_dp.sv
rtl/pscp_ctrl.sv
rtl/periodic_stencil_chemical_potential.sv
tb/tb.sv
